FILE: design/slotted_class_queue_scheduler_defines.svh
// Assertion helpers shared by the scheduler modules.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef SLOTTED_CLASS_QUEUE_SCHEDULER_DEFINES_SVH
`define SLOTTED_CLASS_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SQS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sqs_pkg.sv
`timescale 1ns / 1ps
package sqs_pkg;

  // Kinds of work that the front part hands to the back part.
  localparam logic [1:0] KIND_ARRIVE = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_CLASS_COUNT = 3'd0;
  localparam logic [2:0] REG_SLOT_TICKS  = 3'd1;
  localparam logic [2:0] REG_SVC0        = 3'd2;
  localparam logic [2:0] REG_SVC1        = 3'd3;
  localparam logic [2:0] REG_SVC2        = 3'd4;
  localparam logic [2:0] REG_SVC3        = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  cls;
    logic [15:0] tag;
  } item_t;

  // Effective configuration, with zero and out-of-range values already fixed up.
  typedef struct packed {
    logic [3:0]       eff;
    logic [15:0]      slen;
    logic [3:0][15:0] svc;
  } cfg_t;

  typedef struct packed {
    logic        done_valid;
    logic [15:0] done_tag;
    logic [1:0]  done_class;
    logic        preempt_flag;
    logic        dropped_flag;
    logic        busy_res;
    logic [1:0]  slot_class;
    logic [4:0]  slot_queue_length;
  } res_t;

endpackage

FILE: design/slotted_class_queue_scheduler.sv
`timescale 1ns / 1ps
`include "slotted_class_queue_scheduler_defines.svh"
// Slotted class queue scheduler: one server, one FIFO per class, time-slotted
// round robin between the classes.
// Input channel: drive mode, arrival_class and packet_tag and raise push; the
// beat is taken at a rising edge where push is high and full is low. A mode of
// 1 is one tick of time, a mode of 0 is an arrival. Two beats can wait in the
// input queue, so the source keeps going while the back end works.
// Result channel: every input beat yields exactly one result beat. While empty
// is low the oldest result sits on the result ports; pop takes it. The result
// queue holds two beats, and when it is full the back end stops taking new
// work, which then backs up into full on the input side.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// write only while no beat is in flight.
// Sequencing: an arrival passes through the ARRIVE and FIN states of the back
// end; a tick passes through COMPL, SLOT and FIN, with a load state for each
// FIFO read of the tag store (registered RAM read): CLOAD at service completion
// and, at a slot end, HEAD and then HLOAD for the next slot owner. One beat is
// worked at a time: no new beat is taken until the last one has left FIN.
// Reset (synchronous, rst high) empties both queues and all class FIFOs, idles
// the server, gives the slot to class 0 and restores the default registers.
module slotted_class_queue_scheduler
  import sqs_pkg::*;
#(
  parameter int MAX_CLASSES = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [1:0]  arrival_class,
  input  logic [15:0] packet_tag,
  output logic        empty,
  input  logic        pop,
  output logic        done_valid,
  output logic [15:0] done_tag,
  output logic [1:0]  done_class,
  output logic        preempt_flag,
  output logic        dropped_flag,
  output logic        busy_res,
  output logic [1:0]  slot_class,
  output logic [4:0]  slot_queue_length,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [2:0]       class_count;
  logic [15:0]      slot_ticks;
  logic [3:0][15:0] service_ticks;
  cfg_t             cfg;
  logic [3:0]       cc4;

  item_t      item;
  logic       item_valid;
  logic       item_take;
  logic       res_valid;
  res_t       res;
  res_t       oq [2];
  res_t       head_res;
  logic       oq_wr;
  logic       oq_rd;
  logic [1:0] oq_count;
  logic       out_take;

  // Register file. Indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count   <= 3'd4;
      slot_ticks    <= 16'd100;
      service_ticks <= {4{16'd10}};
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CLASS_COUNT: class_count      <= cfg_data[2:0];
        REG_SLOT_TICKS:  slot_ticks       <= cfg_data;
        REG_SVC0:        service_ticks[0] <= cfg_data;
        REG_SVC1:        service_ticks[1] <= cfg_data;
        REG_SVC2:        service_ticks[2] <= cfg_data;
        REG_SVC3:        service_ticks[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A class count of zero acts as one and is capped at the number of FIFOs;
  // zero durations act as one tick.
  assign cc4 = 4'(class_count);
  always_comb begin
    if (cc4 == 4'd0) begin
      cfg.eff = 4'd1;
    end else if (cc4 > 4'(MAX_CLASSES)) begin
      cfg.eff = 4'(MAX_CLASSES);
    end else begin
      cfg.eff = cc4;
    end
    cfg.slen = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
    for (int i = 0; i < 4; i++) begin
      cfg.svc[i] = (service_ticks[i] == 16'd0) ? 16'd1 : service_ticks[i];
    end
  end

  sqs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .arrival_class(arrival_class),
    .packet_tag   (packet_tag),
    .eff_classes  (cfg.eff),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  sqs_back #(
    .MAX_CLASSES(MAX_CLASSES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_valid(item_valid),
    .item      (item),
    .item_take (item_take),
    .out_space (oq_count != 2'd2),
    .res_valid (res_valid),
    .res       (res)
  );

  // Two-beat result queue. The back end only starts a beat when a slot is
  // free, so a finished result never has to wait.
  assign empty    = (oq_count == 2'd0);
  assign out_take = pop && !empty;
  assign head_res = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (res_valid) begin
        oq_wr <= ~oq_wr;
      end
      if (out_take) begin
        oq_rd <= ~oq_rd;
      end
      oq_count <= oq_count + 2'(res_valid) - 2'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      oq[oq_wr] <= res;
    end
  end

  assign done_valid        = head_res.done_valid;
  assign done_tag          = head_res.done_tag;
  assign done_class        = head_res.done_class;
  assign preempt_flag      = head_res.preempt_flag;
  assign dropped_flag      = head_res.dropped_flag;
  assign busy_res          = head_res.busy_res;
  assign slot_class        = head_res.slot_class;
  assign slot_queue_length = head_res.slot_queue_length;

  `SQS_ASSERT_IMP(a_oq_bound, 1'b1, oq_count <= 2'd2, "top: result queue overflow")
  `SQS_ASSERT_IMP(a_oq_room, res_valid, oq_count != 2'd2, "top: result with no room")

endmodule

FILE: design/sqs_ram.sv
`timescale 1ns / 1ps
module sqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sqs_front.sv
`timescale 1ns / 1ps
`include "slotted_class_queue_scheduler_defines.svh"
module sqs_front
  import sqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [1:0]  arrival_class,
  input  logic [15:0] packet_tag,
  input  logic [3:0]  eff_classes,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  item_t      fq [2];
  item_t      cls_item;
  logic       wr;
  logic       rd;
  logic [1:0] count;
  logic       accept;

  // An arrival of a class outside the rotation is marked here so the back
  // part only has to count it as dropped.
  always_comb begin
    cls_item.cls = arrival_class;
    cls_item.tag = packet_tag;
    if (mode) begin
      cls_item.kind = KIND_TICK;
    end else if (4'(arrival_class) >= eff_classes) begin
      cls_item.kind = KIND_REJECT;
    end else begin
      cls_item.kind = KIND_ARRIVE;
    end
  end

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = fq[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= 1'b0;
      rd    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        wr <= ~wr;
      end
      if (item_take) begin
        rd <= ~rd;
      end
      count <= count + 2'(accept) - 2'(item_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fq[wr] <= cls_item;
    end
  end

  `SQS_ASSERT_IMP(a_take_nonempty, item_take, item_valid, "front: take from empty queue")
  `SQS_ASSERT_NXT(a_accept_shows, accept, item_valid, "front: accepted beat not queued")
  `SQS_ASSERT_IMP(a_count_bound, 1'b1, count <= 2'd2, "front: count overflow")

endmodule

FILE: design/sqs_back.sv
`timescale 1ns / 1ps
`include "slotted_class_queue_scheduler_defines.svh"
module sqs_back
  import sqs_pkg::*;
#(
  parameter int MAX_CLASSES = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_take,
  input  logic  out_space,
  output logic  res_valid,
  output res_t  res
);

  localparam int CB = $clog2(MAX_CLASSES);
  localparam int PB = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = CB + PB;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ARRIVE = 3'd1;
  localparam logic [2:0] ST_COMPL  = 3'd2;
  localparam logic [2:0] ST_CLOAD  = 3'd3;
  localparam logic [2:0] ST_SLOT   = 3'd4;
  localparam logic [2:0] ST_HEAD   = 3'd5;
  localparam logic [2:0] ST_HLOAD  = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]          state;
  logic [PB-1:0]       head [MAX_CLASSES];
  logic [PB-1:0]       tail [MAX_CLASSES];
  logic [FW-1:0]       fill [MAX_CLASSES];
  logic                busy;
  logic [TAG_BITS-1:0] served_tag;
  logic [CB-1:0]       served_class;
  logic [15:0]         service_left;
  logic [15:0]         slot_elapsed;
  logic [CB-1:0]       active_class;
  item_t               cur;
  logic                done_v;
  logic [TAG_BITS-1:0] done_tag_r;
  logic [CB-1:0]       done_cls;
  logic                preempt;
  logic                dropped;
  logic                slot_end;

  logic [CB-1:0]       qsel;
  logic [PB-1:0]       q_head;
  logic [PB-1:0]       q_tail;
  logic [FW-1:0]       q_fill;
  logic                q_full;
  logic                q_empty;
  logic                ram_we;
  logic [TAG_BITS-1:0] ram_wdata;
  logic [TAG_BITS-1:0] ram_rdata;
  logic [31:0]         in_tag32;
  logic [31:0]         out_tag32;
  logic [TAG_BITS-1:0] arr_tag;
  logic [CB-1:0]       arr_cls;
  logic [15:0]         left_dec;
  logic [15:0]         elapsed_inc;
  logic [3:0]          act_inc;
  logic [CB-1:0]       next_active;

  function automatic logic [PB-1:0] ptr_inc(input logic [PB-1:0] p);
    return (p == PB'(QUEUE_DEPTH - 1)) ? '0 : p + PB'(1);
  endfunction

  // Every state touches at most one class FIFO, picked here.
  always_comb begin
    unique case (state)
      ST_ARRIVE:                   qsel = arr_cls;
      ST_COMPL, ST_CLOAD, ST_SLOT: qsel = served_class;
      default:                     qsel = active_class;
    endcase
  end

  assign q_head  = head[qsel];
  assign q_tail  = tail[qsel];
  assign q_fill  = fill[qsel];
  assign q_full  = (q_fill == FW'(QUEUE_DEPTH));
  assign q_empty = (q_fill == '0);

  assign in_tag32 = 32'(cur.tag);
  assign arr_tag  = in_tag32[TAG_BITS-1:0];
  assign arr_cls  = CB'(cur.cls);

  assign left_dec    = (service_left != 16'd0) ? service_left - 16'd1 : 16'd0;
  assign elapsed_inc = slot_elapsed + 16'd1;
  assign act_inc     = 4'(active_class) + 4'd1;
  assign next_active = (act_inc >= cfg.eff) ? '0 : CB'(act_inc);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = arr_tag;
    if (state == ST_ARRIVE && cur.kind == KIND_ARRIVE && !q_full &&
        !(!busy && arr_cls == active_class)) begin
      ram_we = 1'b1;
    end else if (state == ST_SLOT && slot_end && busy && !q_full) begin
      ram_we    = 1'b1;
      ram_wdata = served_tag;
    end
  end

  sqs_ram #(
    .WIDTH(TAG_BITS),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr({qsel, q_tail}),
    .wdata(ram_wdata),
    .raddr({qsel, q_head}),
    .rdata(ram_rdata)
  );

  assign item_take = (state == ST_IDLE) && item_valid && out_space;
  assign res_valid = (state == ST_FIN);

  always_comb begin
    out_tag32             = 32'(done_tag_r);
    res.done_valid        = done_v;
    res.done_tag          = out_tag32[15:0];
    res.done_class        = 2'(done_cls);
    res.preempt_flag      = preempt;
    res.dropped_flag      = dropped;
    res.busy_res          = busy;
    res.slot_class        = 2'(active_class);
    res.slot_queue_length = 5'(q_fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      busy         <= 1'b0;
      served_tag   <= '0;
      served_class <= '0;
      service_left <= '0;
      slot_elapsed <= '0;
      active_class <= '0;
      done_v       <= 1'b0;
      done_tag_r   <= '0;
      done_cls     <= '0;
      preempt      <= 1'b0;
      dropped      <= 1'b0;
      slot_end     <= 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_take) begin
            cur        <= item;
            done_v     <= 1'b0;
            done_tag_r <= '0;
            done_cls   <= '0;
            preempt    <= 1'b0;
            dropped    <= 1'b0;
            slot_end   <= 1'b0;
            state      <= (item.kind == KIND_TICK) ? ST_COMPL : ST_ARRIVE;
          end
        end
        ST_ARRIVE: begin
          if (cur.kind == KIND_REJECT) begin
            dropped <= 1'b1;
          end else if (!busy && arr_cls == active_class) begin
            busy         <= 1'b1;
            served_tag   <= arr_tag;
            served_class <= arr_cls;
            service_left <= cfg.svc[2'(arr_cls)];
          end else if (q_full) begin
            dropped <= 1'b1;
          end else begin
            tail[qsel] <= ptr_inc(q_tail);
            fill[qsel] <= q_fill + FW'(1);
          end
          state <= ST_FIN;
        end
        ST_COMPL: begin
          state <= ST_SLOT;
          if (busy) begin
            service_left <= left_dec;
            if (left_dec == 16'd0) begin
              done_v     <= 1'b1;
              done_tag_r <= served_tag;
              done_cls   <= served_class;
              busy       <= 1'b0;
              if (!q_empty) begin
                head[qsel] <= ptr_inc(q_head);
                fill[qsel] <= q_fill - FW'(1);
                state      <= ST_CLOAD;
              end
            end
          end
          if (elapsed_inc >= cfg.slen) begin
            slot_end     <= 1'b1;
            slot_elapsed <= '0;
          end else begin
            slot_elapsed <= elapsed_inc;
          end
        end
        ST_CLOAD: begin
          busy         <= 1'b1;
          served_tag   <= ram_rdata;
          service_left <= cfg.svc[2'(served_class)];
          state        <= ST_SLOT;
        end
        ST_SLOT: begin
          if (slot_end) begin
            if (busy) begin
              preempt <= 1'b1;
              busy    <= 1'b0;
              if (q_full) begin
                dropped <= 1'b1;
              end else begin
                tail[qsel] <= ptr_inc(q_tail);
                fill[qsel] <= q_fill + FW'(1);
              end
            end
            active_class <= next_active;
            state        <= ST_HEAD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_HEAD: begin
          if (!q_empty) begin
            head[qsel] <= ptr_inc(q_head);
            fill[qsel] <= q_fill - FW'(1);
            state      <= ST_HLOAD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_HLOAD: begin
          busy         <= 1'b1;
          served_class <= active_class;
          served_tag   <= ram_rdata;
          service_left <= cfg.svc[2'(active_class)];
          state        <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SQS_ASSERT_NXT(a_fin_idle, state == ST_FIN, state == ST_IDLE, "back: result not retired")
  `SQS_ASSERT_IMP(a_cload_src, state == ST_CLOAD, $past(state) == ST_COMPL,
                  "back: completion load out of order")
  `SQS_ASSERT_IMP(a_fill_bound, 1'b1, q_fill <= FW'(QUEUE_DEPTH), "back: FIFO overfilled")

endmodule
